FILE: design/npcm_pkg.sv
// npcm_pkg: shared types and constants for the nearest palette color matcher
// no dependencies; used by every module of the block by scoped names

package npcm_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CHAN_W          = 8;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = SQ_W + 2;
    localparam int ENTRY_IN_W      = 8;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);

    // input kind codes
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_DIM   = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_MATCH,
        OP_DIM
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: design/nearest_palette_color_match.sv
// nearest palette color match: a write passes the front register and the command queue before it
// reaches the palette, and one write transfer per cycle is sustained while the back side is idle
// match: all entries are read and pass stage one, stage two and the result register, back busy
// throughout, set by the one-entry-per-cycle palette read port; dim: back busy likewise, same read
// port, entries halved and written back; a two-entry command queue decouples input and engine
// synchronous active-low reset; palette reads as black after reset via per-entry valid bits

module nearest_palette_color_match (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_match_index
);

    // front to queue
    logic              w_f_valid;
    npcm_pkg::t_cmd    w_f_cmd;
    logic              w_f_ready;
    logic              w_push;

    // queue to back
    npcm_pkg::t_cmd    w_q_cmd;
    npcm_pkg::t_q_stat w_q_stat;
    logic              w_pop;

    logic [npcm_pkg::IDX_W-1:0] w_match_idx;

    // front side: registers and classifies one item, drops unused kinds
    npcm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_cmd_valid   (w_f_valid),
        .o_cmd         (w_f_cmd),
        .i_cmd_ready   (w_f_ready)
    );

    // command transfer into the queue whenever it has room
    assign w_f_ready = !w_q_stat.full;
    assign w_push    = w_f_valid && w_f_ready;

    npcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_f_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    // back side: palette memory and the scan engine, one command at a time
    npcm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!w_q_stat.empty),
        .i_cmd         (w_q_cmd),
        .o_cmd_pop     (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_index (w_match_idx)
    );

    // result index widened to the port width (equal for a full palette)
    assign o_match_index = 8'(w_match_idx);

    // queue never takes a transfer while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("command queue overflow");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("command queue underflow");

    // no result is pending right after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

FILE: design/npcm_front.sv
// npcm_front: accepts input items, classifies them and registers one command
// depends on npcm_pkg; feeds the command queue

module npcm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [npcm_pkg::ENTRY_IN_W-1:0] i_entry_index,
    input  logic [npcm_pkg::CHAN_W-1:0]   i_red,
    input  logic [npcm_pkg::CHAN_W-1:0]   i_green,
    input  logic [npcm_pkg::CHAN_W-1:0]   i_blue,
    output logic                          o_cmd_valid,
    output npcm_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_ready
);

    logic           r_vld;
    npcm_pkg::t_cmd r_cmd;
    logic           w_keep;
    npcm_pkg::t_op  w_op;
    logic           w_in_range;

    assign o_in_ready  = !r_vld || i_cmd_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    assign w_in_range = {1'b0, i_entry_index} < (npcm_pkg::ENTRY_IN_W + 1)'(npcm_pkg::PALETTE_ENTRIES);

    // unused kind and out-of-range writes are dropped here
    always_comb begin
        w_keep = 1'b0;
        w_op   = npcm_pkg::OP_MATCH;
        unique case (i_kind)
            npcm_pkg::KIND_WRITE: begin
                w_keep = w_in_range;
                w_op   = npcm_pkg::OP_WRITE;
            end
            npcm_pkg::KIND_MATCH: begin
                w_keep = 1'b1;
                w_op   = npcm_pkg::OP_MATCH;
            end
            npcm_pkg::KIND_DIM: begin
                w_keep = 1'b1;
                w_op   = npcm_pkg::OP_DIM;
            end
            default: begin
                w_keep = 1'b0;
                w_op   = npcm_pkg::OP_MATCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd.op    <= w_op;
            r_cmd.idx   <= i_entry_index[npcm_pkg::IDX_W-1:0];
            r_cmd.red   <= i_red;
            r_cmd.green <= i_green;
            r_cmd.blue  <= i_blue;
        end
    end

endmodule

FILE: design/npcm_queue.sv
// npcm_queue: short command queue between front and back
// depends on npcm_pkg

module npcm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  npcm_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output npcm_pkg::t_cmd    o_cmd,
    output npcm_pkg::t_q_stat o_stat
);

    npcm_pkg::t_cmd            r_mem [npcm_pkg::QDEPTH];
    logic [npcm_pkg::QPTR_W-1:0] r_wp;
    logic [npcm_pkg::QPTR_W-1:0] r_rp;
    logic [npcm_pkg::QPTR_W:0]   r_count;

    assign o_stat.full  = r_count == (npcm_pkg::QPTR_W + 1)'(npcm_pkg::QDEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: design/npcm_back.sv
// npcm_back: palette memory, scan pipeline for match and dim, result register
// depends on npcm_pkg; takes commands from the queue

module npcm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  npcm_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [npcm_pkg::IDX_W-1:0]   o_match_index
);

    localparam logic [npcm_pkg::IDX_W-1:0] LAST_IDX =
        npcm_pkg::IDX_W'(npcm_pkg::PALETTE_ENTRIES - 1);

    npcm_pkg::t_back_state r_state, n_state;
    npcm_pkg::t_op         r_op;
    logic [npcm_pkg::CHAN_W-1:0] r_qr, r_qg, r_qb;
    logic [npcm_pkg::IDX_W-1:0]  r_cnt;

    // palette storage with per-entry valid bits (invalid reads as black)
    logic [3*npcm_pkg::CHAN_W-1:0] r_pal [npcm_pkg::PALETTE_ENTRIES];
    logic [npcm_pkg::PALETTE_ENTRIES-1:0] r_pal_vld;
    logic [3*npcm_pkg::CHAN_W-1:0] r_rd_data;
    logic                          r_rd_vld;

    logic                          r_s1_vld;
    logic [npcm_pkg::IDX_W-1:0]    r_s1_idx;
    logic                          r_s2_vld;
    logic [npcm_pkg::IDX_W-1:0]    r_s2_idx;
    logic [npcm_pkg::SQ_W-1:0]     r_sq_r, r_sq_g, r_sq_b;
    logic [npcm_pkg::DIST_W-1:0]   r_best;
    logic [npcm_pkg::IDX_W-1:0]    r_best_idx;
    logic                          r_out_vld;
    logic [npcm_pkg::IDX_W-1:0]    r_out_idx;

    logic                          w_rd_en;
    logic                          w_we;
    logic [npcm_pkg::IDX_W-1:0]    w_waddr;
    logic [3*npcm_pkg::CHAN_W-1:0] w_wdata;
    logic                          w_start;
    logic                          w_load_out;
    logic [3*npcm_pkg::CHAN_W-1:0] w_entry;
    logic [npcm_pkg::CHAN_W-1:0]   w_er, w_eg, w_eb;
    logic [npcm_pkg::CHAN_W-1:0]   w_dr, w_dg, w_db;
    logic [npcm_pkg::DIST_W-1:0]   w_dist;

    assign o_out_valid   = r_out_vld;
    assign o_match_index = r_out_idx;

    // controller
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        w_start    = 1'b0;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            npcm_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && i_cmd.op != npcm_pkg::OP_WRITE) begin
                    w_start = 1'b1;
                    n_state = npcm_pkg::ST_SCAN;
                end
            end
            npcm_pkg::ST_SCAN: begin
                w_rd_en = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = npcm_pkg::ST_DRAIN;
                end
            end
            npcm_pkg::ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    if (r_op != npcm_pkg::OP_MATCH) begin
                        n_state = npcm_pkg::ST_IDLE;
                    end else if (!r_out_vld || i_out_ready) begin
                        w_load_out = 1'b1;
                        n_state    = npcm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = npcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_op <= i_cmd.op;
            r_qr <= i_cmd.red;
            r_qg <= i_cmd.green;
            r_qb <= i_cmd.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_start) begin
            r_cnt <= '0;
        end else if (w_rd_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // memory write port: write items from idle, dim write-back from stage one
    always_comb begin
        w_entry = r_rd_vld ? r_rd_data : '0;
        w_er    = w_entry[3*npcm_pkg::CHAN_W-1 -: npcm_pkg::CHAN_W];
        w_eg    = w_entry[2*npcm_pkg::CHAN_W-1 -: npcm_pkg::CHAN_W];
        w_eb    = w_entry[npcm_pkg::CHAN_W-1:0];
        if (r_state == npcm_pkg::ST_IDLE) begin
            w_we    = i_cmd_valid && i_cmd.op == npcm_pkg::OP_WRITE;
            w_waddr = i_cmd.idx;
            w_wdata = {i_cmd.red, i_cmd.green, i_cmd.blue};
        end else begin
            w_we    = r_s1_vld && r_op == npcm_pkg::OP_DIM;
            w_waddr = r_s1_idx;
            w_wdata = {w_er >> 1, w_eg >> 1, w_eb >> 1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_pal[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_pal[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (w_we) begin
                r_pal_vld[w_waddr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_pal_vld[r_cnt];
            end
        end
    end

    // stage one: channel differences and squares
    assign w_dr = (w_er >= r_qr) ? w_er - r_qr : r_qr - w_er;
    assign w_dg = (w_eg >= r_qg) ? w_eg - r_qg : r_qg - w_eg;
    assign w_db = (w_eb >= r_qb) ? w_eb - r_qb : r_qb - w_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_rd_en;
            r_s2_vld <= r_s1_vld && r_op == npcm_pkg::OP_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_cnt;
        r_s2_idx <= r_s1_idx;
        r_sq_r   <= w_dr * w_dr;
        r_sq_g   <= w_dg * w_dg;
        r_sq_b   <= w_db * w_db;
    end

    // stage two: distance sum and running minimum, entry zero seeds the best
    assign w_dist = npcm_pkg::DIST_W'(r_sq_r) + npcm_pkg::DIST_W'(r_sq_g)
                  + npcm_pkg::DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (r_s2_idx == '0 || w_dist < r_best)) begin
            r_best     <= w_dist;
            r_best_idx <= r_s2_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_idx <= r_best_idx;
        end
    end

endmodule
